/* rtl/scad_pkg.sv */
// scad_pkg: shared widths, types, register codes and constant tables
// for the sin/cos stroke angle decoder; used by every rtl module
// no dependencies
package scad_pkg;

    localparam int SAMPLE_BITS       = 15;
    localparam int ANGLE_FRAC_BITS   = 16;
    localparam int CORDIC_ITERATIONS = 16;

    localparam int SCALE_W    = 32;
    localparam int Z_W        = 32;
    localparam int NORM_TOP   = 46;
    localparam int MAG_W      = (SAMPLE_BITS + SCALE_W > NORM_TOP + 2) ?
                                (SAMPLE_BITS + SCALE_W) : (NORM_TOP + 2);
    localparam int PROD_W     = MAG_W + 1;
    localparam int CORD_W     = MAG_W + 3;
    localparam int PHI_W      = ANGLE_FRAC_BITS + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FRONT_STAGES = 6;

    typedef logic [SAMPLE_BITS-1:0]        t_sample;
    typedef logic [SCALE_W-1:0]            t_scale;
    typedef logic [ANGLE_FRAC_BITS-1:0]    t_angle;
    typedef logic signed [PHI_W-1:0]       t_phi;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic [MAG_W-1:0]              t_mag;
    typedef logic signed [CORD_W-1:0]      t_cord;
    typedef logic [Z_W-1:0]                t_z;
    typedef logic [CFG_IDX_W-1:0]          t_cfg_idx;

    localparam t_cfg_idx REG_SINE_OFFSET   = 3'd0;
    localparam t_cfg_idx REG_SINE_SCALE    = 3'd1;
    localparam t_cfg_idx REG_COSINE_OFFSET = 3'd2;
    localparam t_cfg_idx REG_COSINE_SCALE  = 3'd3;
    localparam t_cfg_idx REG_UPSTROKE      = 3'd4;
    localparam t_cfg_idx REG_DOWNSTROKE    = 3'd5;

    localparam t_sample OFFSET_RESET = t_sample'(1 << (SAMPLE_BITS - 1));
    localparam t_scale  SCALE_RESET  = t_scale'(65536);
    localparam t_z      HALF_TURN_Z  = t_z'(1) << (Z_W - 1);

    // vector pair with the running magnitude used for the leading-zero shift
    typedef struct packed {
        t_prod x;
        t_prod y;
        t_mag  m;
    } t_norm;

    // rotation state handed through the cordic stages
    typedef struct packed {
        t_cord x;
        t_cord y;
        t_z    z;
        logic  zero;
    } t_rot;

    // one greedy step of the normalize: shift by k if the top stays below bit NORM_TOP+1
    function automatic t_norm norm_step(input t_norm v, input int k);
        t_norm r;
        r = v;
        if ((v.m >> (NORM_TOP + 1 - k)) == '0) begin
            r.x = v.x <<< k;
            r.y = v.y <<< k;
            r.m = v.m << k;
        end
        return r;
    endfunction

    // atan(2^-i) as a fraction of a turn, 32 bits, rounded
    function automatic t_z atan_turn(input int i);
        t_z r;
        case (i)
            0:       r = 32'h20000000;
            1:       r = 32'h12E4051E;
            2:       r = 32'h09FB385B;
            3:       r = 32'h051111D4;
            4:       r = 32'h028B0D43;
            5:       r = 32'h0145D7E1;
            6:       r = 32'h00A2F61E;
            7:       r = 32'h00517C55;
            8:       r = 32'h0028BE53;
            9:       r = 32'h00145F2F;
            10:      r = 32'h000A2F98;
            11:      r = 32'h000517CC;
            12:      r = 32'h00028BE6;
            13:      r = 32'h000145F3;
            14:      r = 32'h0000A2FA;
            15:      r = 32'h0000517D;
            16:      r = 32'h000028BE;
            17:      r = 32'h0000145F;
            18:      r = 32'h00000A30;
            19:      r = 32'h00000518;
            20:      r = 32'h0000028C;
            21:      r = 32'h00000146;
            22:      r = 32'h000000A3;
            23:      r = 32'h00000051;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/scad_front.sv */
// scad_front: offset/gain multiply, magnitude, staged leading-zero normalize
// and half-turn pre-rotation; six register stages
// depends on scad_pkg
module scad_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  scad_pkg::t_sample i_sine_sample,
    input  scad_pkg::t_sample i_cosine_sample,
    input  scad_pkg::t_sample i_sine_offset,
    input  scad_pkg::t_scale  i_sine_scale,
    input  scad_pkg::t_sample i_cosine_offset,
    input  scad_pkg::t_scale  i_cosine_scale,
    output logic              o_valid,
    output scad_pkg::t_rot    o_rot
);

    localparam int DIFF_W = scad_pkg::SAMPLE_BITS + 1;
    localparam int FULL_W = DIFF_W + scad_pkg::SCALE_W + 1;

    logic [scad_pkg::FRONT_STAGES-1:0] r_vld;

    logic signed [DIFF_W-1:0]                 sd, cd;
    logic signed [scad_pkg::SCALE_W:0]        ss, cs;
    logic signed [FULL_W-1:0]                 y_full, x_full;
    scad_pkg::t_prod                          r_y1, r_x1;
    scad_pkg::t_prod                          ax, ay;
    scad_pkg::t_norm                          n_n2, r_n2, n_n3, r_n3, n_n4, r_n4, n_n5, r_n5;
    scad_pkg::t_rot                           n_rot, r_rot;

    // stage 1: remove midpoint and apply gain
    assign sd = $signed({1'b0, i_sine_sample}) - $signed({1'b0, i_sine_offset});
    assign cd = $signed({1'b0, i_cosine_sample}) - $signed({1'b0, i_cosine_offset});
    assign ss = $signed({1'b0, i_sine_scale});
    assign cs = $signed({1'b0, i_cosine_scale});
    assign y_full = sd * ss;
    assign x_full = cd * cs;

    // stage 2: magnitudes, or of both has the same leading one as the max
    assign ax = r_x1[scad_pkg::PROD_W-1] ? -r_x1 : r_x1;
    assign ay = r_y1[scad_pkg::PROD_W-1] ? -r_y1 : r_y1;
    always_comb begin
        n_n2.x = r_x1;
        n_n2.y = r_y1;
        n_n2.m = scad_pkg::MAG_W'(ax) | scad_pkg::MAG_W'(ay);
    end

    // stages 3 to 5: two shift steps each
    assign n_n3 = scad_pkg::norm_step(scad_pkg::norm_step(r_n2, 32), 16);
    assign n_n4 = scad_pkg::norm_step(scad_pkg::norm_step(r_n3, 8), 4);
    assign n_n5 = scad_pkg::norm_step(scad_pkg::norm_step(r_n4, 2), 1);

    // stage 6: fold the left half plane onto the right one
    always_comb begin
        n_rot.zero = (r_n5.m == '0);
        if (r_n5.x[scad_pkg::PROD_W-1]) begin
            n_rot.x = -scad_pkg::CORD_W'(r_n5.x);
            n_rot.y = -scad_pkg::CORD_W'(r_n5.y);
            n_rot.z = scad_pkg::HALF_TURN_Z;
        end else begin
            n_rot.x = scad_pkg::CORD_W'(r_n5.x);
            n_rot.y = scad_pkg::CORD_W'(r_n5.y);
            n_rot.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[scad_pkg::FRONT_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y1  <= scad_pkg::PROD_W'(y_full);
            r_x1  <= scad_pkg::PROD_W'(x_full);
            r_n2  <= n_n2;
            r_n3  <= n_n3;
            r_n4  <= n_n4;
            r_n5  <= n_n5;
            r_rot <= n_rot;
        end
    end

    assign o_valid = r_vld[scad_pkg::FRONT_STAGES-1];
    assign o_rot   = r_rot;

endmodule

/* rtl/scad_cordic.sv */
// scad_cordic: vectoring cordic, one micro-rotation per register stage
// depends on scad_pkg (widths, atan table)
module scad_cordic (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  scad_pkg::t_rot i_rot,
    output logic           o_valid,
    output scad_pkg::t_rot o_rot
);

    localparam int N = scad_pkg::CORDIC_ITERATIONS;

    wire scad_pkg::t_rot s_rot [N+1];
    wire                 s_vld [N+1];

    assign s_rot[0] = i_rot;
    assign s_vld[0] = i_valid;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_iter
            scad_pkg::t_cord xs, ys;
            scad_pkg::t_rot  n_rot, r_rot;
            logic            r_vld;

            assign xs = $signed(s_rot[g].x) >>> g;
            assign ys = $signed(s_rot[g].y) >>> g;

            always_comb begin
                n_rot.zero = s_rot[g].zero;
                if (!s_rot[g].y[scad_pkg::CORD_W-1]) begin
                    n_rot.x = s_rot[g].x + ys;
                    n_rot.y = s_rot[g].y - xs;
                    n_rot.z = s_rot[g].z + scad_pkg::atan_turn(g);
                end else begin
                    n_rot.x = s_rot[g].x - ys;
                    n_rot.y = s_rot[g].y + xs;
                    n_rot.z = s_rot[g].z - scad_pkg::atan_turn(g);
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld <= 1'b0;
                end else if (i_en) begin
                    r_vld <= s_vld[g];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rot <= n_rot;
                end
            end

            assign s_rot[g+1] = r_rot;
            assign s_vld[g+1] = r_vld;
        end
    endgenerate

    assign o_valid = s_vld[N];
    assign o_rot   = s_rot[N];

endmodule

/* rtl/scad_stroke.sv */
// scad_stroke: angle rounding, then stroke angle from the limit angles;
// two register stages, the second is the output register
// depends on scad_pkg
module scad_stroke (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  scad_pkg::t_rot   i_rot,
    input  scad_pkg::t_angle i_upstroke,
    input  scad_pkg::t_angle i_downstroke,
    output logic             o_valid,
    output scad_pkg::t_angle o_raw_angle,
    output scad_pkg::t_phi   o_stroke_phi
);

    localparam int AF  = scad_pkg::ANGLE_FRAC_BITS;
    localparam int SUM_W = AF + 3;
    localparam logic [AF:0] TURN = (AF + 1)'(1) << AF;
    localparam scad_pkg::t_angle HALF = scad_pkg::t_angle'(1) << (AF - 1);
    localparam scad_pkg::t_z ROUND = scad_pkg::t_z'(1) << (31 - AF);

    logic [1:0]        r_vld;
    scad_pkg::t_z      zsum;
    scad_pkg::t_angle  n_raw, r_raw, r_raw_out;
    logic [AF:0]       up_e, dn_e, t1, t2, t_arc;
    logic              dir_pos;
    scad_pkg::t_angle  d_u;
    logic signed [AF:0] d_s;
    logic signed [SUM_W-1:0] d2, sum;
    scad_pkg::t_phi    n_phi, r_phi;

    // round half up to the output angle, vector of zero length reads as zero
    assign zsum  = i_rot.z + ROUND;
    assign n_raw = i_rot.zero ? '0 : zsum[scad_pkg::Z_W-1 -: AF];

    // direction and half-arc offset along the shorter arc
    assign up_e = {1'b0, i_upstroke};
    assign dn_e = {1'b0, i_downstroke};
    assign t1 = (i_upstroke > i_downstroke) ? (up_e - dn_e) : (up_e + TURN - dn_e);
    assign t2 = (i_downstroke > i_upstroke) ? (dn_e - up_e) : (dn_e + TURN - up_e);
    assign dir_pos = (t1 < t2);
    assign t_arc = dir_pos ? t1 : t2;

    // raw minus downstroke, wrapped to (-1/2, 1/2] turn
    assign d_u = r_raw - i_downstroke;
    always_comb begin
        d_s = $signed({1'b0, d_u});
        if (d_u > HALF) begin
            d_s = $signed({1'b0, d_u}) - $signed(TURN);
        end
    end

    assign d2  = SUM_W'(d_s) <<< 1;
    assign sum = (dir_pos ? d2 : -d2) - $signed(SUM_W'(t_arc)) + SUM_W'(1);
    assign n_phi = scad_pkg::PHI_W'(sum >>> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_raw     <= n_raw;
            r_raw_out <= r_raw;
            r_phi     <= n_phi;
        end
    end

    assign o_valid      = r_vld[1];
    assign o_raw_angle  = r_raw_out;
    assign o_stroke_phi = r_phi;

endmodule

/* rtl/sincos_stroke_angle_decoder_unit.sv */
// sincos_stroke_angle_decoder_unit: sin/cos sensor angle decoder, top level
// holds the configuration registers and the pipeline stall control
// depends on scad_pkg, scad_front, scad_cordic, scad_stroke
//
// Input channel i_in_valid/o_in_ready carries one word of two raw adc samples.
// Output channel o_out_valid/i_out_ready carries one word per input word:
// the raw atan2 angle (fraction of a turn) and the signed stroke angle.
// From acceptance to o_out_valid a word passes 6 front stages
// (gain multiply, magnitude, three normalize stages, pre-rotation), one stage
// per cordic iteration (16) and 2 stroke stages, the last being the output
// register. Throughput is one word per cycle while the receiver takes words.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// o_in_ready drops; nothing is lost or repeated, bubbles are not squeezed out.
// Configuration is written through i_cfg_wr_en/i_cfg_index/i_cfg_data at any
// edge and takes effect at once; write it only while the pipeline is empty.
// Unknown register indexes are ignored. Reset (synchronous, active low)
// empties the pipeline and loads the default gains, offsets and limit angles.
module sincos_stroke_angle_decoder_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [scad_pkg::SAMPLE_BITS-1:0]    i_sine_sample,
    input  logic [scad_pkg::SAMPLE_BITS-1:0]    i_cosine_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [scad_pkg::ANGLE_FRAC_BITS-1:0] o_raw_angle,
    output logic signed [scad_pkg::PHI_W-1:0]   o_stroke_phi,
    input  logic                                i_cfg_wr_en,
    input  logic [scad_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [scad_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    scad_pkg::t_sample r_sine_offset, r_cosine_offset;
    scad_pkg::t_scale  r_sine_scale, r_cosine_scale;
    scad_pkg::t_angle  r_upstroke, r_downstroke;

    logic           en;
    logic           front_vld, cordic_vld;
    scad_pkg::t_rot front_rot, cordic_rot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sine_offset   <= scad_pkg::OFFSET_RESET;
            r_sine_scale    <= scad_pkg::SCALE_RESET;
            r_cosine_offset <= scad_pkg::OFFSET_RESET;
            r_cosine_scale  <= scad_pkg::SCALE_RESET;
            r_upstroke      <= '0;
            r_downstroke    <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                scad_pkg::REG_SINE_OFFSET: begin
                    r_sine_offset <= i_cfg_data[scad_pkg::SAMPLE_BITS-1:0];
                end
                scad_pkg::REG_SINE_SCALE: begin
                    r_sine_scale <= i_cfg_data[scad_pkg::SCALE_W-1:0];
                end
                scad_pkg::REG_COSINE_OFFSET: begin
                    r_cosine_offset <= i_cfg_data[scad_pkg::SAMPLE_BITS-1:0];
                end
                scad_pkg::REG_COSINE_SCALE: begin
                    r_cosine_scale <= i_cfg_data[scad_pkg::SCALE_W-1:0];
                end
                scad_pkg::REG_UPSTROKE: begin
                    r_upstroke <= i_cfg_data[scad_pkg::ANGLE_FRAC_BITS-1:0];
                end
                scad_pkg::REG_DOWNSTROKE: begin
                    r_downstroke <= i_cfg_data[scad_pkg::ANGLE_FRAC_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // pipeline moves unless a finished word sits unread at the output
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    scad_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (i_in_valid),
        .i_sine_sample   (i_sine_sample),
        .i_cosine_sample (i_cosine_sample),
        .i_sine_offset   (r_sine_offset),
        .i_sine_scale    (r_sine_scale),
        .i_cosine_offset (r_cosine_offset),
        .i_cosine_scale  (r_cosine_scale),
        .o_valid         (front_vld),
        .o_rot           (front_rot)
    );

    scad_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_vld),
        .i_rot   (front_rot),
        .o_valid (cordic_vld),
        .o_rot   (cordic_rot)
    );

    scad_stroke u_stroke (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (cordic_vld),
        .i_rot        (cordic_rot),
        .i_upstroke   (r_upstroke),
        .i_downstroke (r_downstroke),
        .o_valid      (o_out_valid),
        .o_raw_angle  (o_raw_angle),
        .o_stroke_phi (o_stroke_phi)
    );

endmodule

/* tb/testbench.sv */
// testbench for sincos_stroke_angle_decoder_unit: directed table, then random calibration phases
// an in-file predictor of the atan2 cordic and stroke angle checks every output word
// depends on scad_pkg and the rtl of the decoder
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam scad_pkg::t_cfg_idx REG_SPARE_LO = 3'd6;
    localparam scad_pkg::t_cfg_idx REG_SPARE_HI = 3'd7;

    localparam int IDLE_LIMIT      = 2000;
    localparam int END_SETTLE      = 40;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 235;

    localparam longint NORM_FLOOR = longint'(1) << scad_pkg::NORM_TOP;

    // atan(2^-i) in 32-bit turns
    localparam scad_pkg::t_z ATAN_TURNS [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        scad_pkg::t_angle raw;
        scad_pkg::t_phi   phi;
    } t_angle_word;

    typedef struct packed {
        logic               wr;
        scad_pkg::t_cfg_idx idx;
        logic [31:0]        data;
        scad_pkg::t_sample  sine;
        scad_pkg::t_sample  cosine;
        logic               typed;
        t_angle_word        word;
    } t_probe_row;

    // zero vector with equal limit angles: raw 0, phi is minus half a turn
    localparam t_angle_word ZERO_EQUAL_WORD = '{raw: '0, phi: -18'sd32768};
    localparam t_angle_word NO_WORD         = '0;

    localparam int PROBE_ROWS = 42;
    localparam t_probe_row PROBES [0:PROBE_ROWS-1] = '{
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd16384, 15'd16384, 1'b1, ZERO_EQUAL_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd0, 15'd0, 1'b0, NO_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd32767, 15'd32767, 1'b0, NO_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd0, 15'd32767, 1'b0, NO_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd32767, 15'd0, 1'b0, NO_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd32767, 15'd16384, 1'b0, NO_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd16384, 15'd32767, 1'b0, NO_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd16385, 15'd16384, 1'b0, NO_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd16384, 15'd16383, 1'b0, NO_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd16383, 15'd16384, 1'b0, NO_WORD},
        '{1'b1, scad_pkg::REG_SINE_SCALE, 32'd0, 15'd0, 15'd0, 1'b0, NO_WORD},
        '{1'b1, scad_pkg::REG_COSINE_SCALE, 32'd0, 15'd0, 15'd0, 1'b0, NO_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd12345, 15'd999, 1'b1, ZERO_EQUAL_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd32767, 15'd0, 1'b1, ZERO_EQUAL_WORD},
        '{1'b1, scad_pkg::REG_SINE_SCALE, 32'hFFFFFFFF, 15'd0, 15'd0, 1'b0, NO_WORD},
        '{1'b1, scad_pkg::REG_COSINE_SCALE, 32'hFFFFFFFF, 15'd0, 15'd0, 1'b0, NO_WORD},
        '{1'b1, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd0, 15'd0, 1'b0, NO_WORD},
        '{1'b1, scad_pkg::REG_COSINE_OFFSET, 32'd32767, 15'd0, 15'd0, 1'b0, NO_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd32767, 15'd0, 1'b0, NO_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd0, 15'd32767, 1'b1, ZERO_EQUAL_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd32767, 15'd32767, 1'b0, NO_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd1, 15'd32766, 1'b0, NO_WORD},
        '{1'b1, scad_pkg::REG_SINE_OFFSET, 32'd32767, 15'd0, 15'd0, 1'b0, NO_WORD},
        '{1'b1, scad_pkg::REG_COSINE_OFFSET, 32'd0, 15'd0, 15'd0, 1'b0, NO_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd0, 15'd32767, 1'b0, NO_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd0, 15'd0, 1'b0, NO_WORD},
        '{1'b1, scad_pkg::REG_UPSTROKE, 32'h00004000, 15'd0, 15'd0, 1'b0, NO_WORD},
        '{1'b1, scad_pkg::REG_DOWNSTROKE, 32'h0000C000, 15'd0, 15'd0, 1'b0, NO_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd32767, 15'd1, 1'b0, NO_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd0, 15'd16384, 1'b0, NO_WORD},
        '{1'b1, scad_pkg::REG_UPSTROKE, 32'h00001000, 15'd0, 15'd0, 1'b0, NO_WORD},
        '{1'b1, scad_pkg::REG_DOWNSTROKE, 32'h0000F000, 15'd0, 15'd0, 1'b0, NO_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd16000, 15'd30000, 1'b0, NO_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd500, 15'd200, 1'b0, NO_WORD},
        '{1'b1, scad_pkg::REG_UPSTROKE, 32'h0000FFFF, 15'd0, 15'd0, 1'b0, NO_WORD},
        '{1'b1, scad_pkg::REG_DOWNSTROKE, 32'h00000000, 15'd0, 15'd0, 1'b0, NO_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd0, 15'd0, 1'b0, NO_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd32767, 15'd32767, 1'b0, NO_WORD},
        // upper bits dropped, so down equals up
        '{1'b1, scad_pkg::REG_DOWNSTROKE, 32'h0001FFFF, 15'd0, 15'd0, 1'b0, NO_WORD},
        '{1'b1, REG_SPARE_HI, 32'hDEADBEEF, 15'd0, 15'd0, 1'b0, NO_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd20000, 15'd100, 1'b0, NO_WORD},
        '{1'b0, scad_pkg::REG_SINE_OFFSET, 32'd0, 15'd9000, 15'd31000, 1'b0, NO_WORD}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    scad_pkg::t_sample  i_sine_sample = '0;
    scad_pkg::t_sample  i_cosine_sample = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    scad_pkg::t_angle   o_raw_angle;
    scad_pkg::t_phi     o_stroke_phi;
    logic               i_cfg_wr_en = 1'b0;
    scad_pkg::t_cfg_idx i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    // calibration as the block should hold it
    scad_pkg::t_sample cal_sine_offset = scad_pkg::OFFSET_RESET;
    scad_pkg::t_scale  cal_sine_gain   = scad_pkg::SCALE_RESET;
    scad_pkg::t_sample cal_cos_offset  = scad_pkg::OFFSET_RESET;
    scad_pkg::t_scale  cal_cos_gain    = scad_pkg::SCALE_RESET;
    scad_pkg::t_angle  cal_up_angle    = '0;
    scad_pkg::t_angle  cal_down_angle  = '0;

    t_angle_word angles_in_flight [$];
    int          mismatch_count = 0;
    bit          word_offered = 1'b0;
    int          send_run = 0;
    int          take_run = 0;

    sincos_stroke_angle_decoder_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_sine_sample   (i_sine_sample),
        .i_cosine_sample (i_cosine_sample),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_raw_angle     (o_raw_angle),
        .o_stroke_phi    (o_stroke_phi),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic scad_pkg::t_angle atan2_turn(input scad_pkg::t_sample sine,
                                                    input scad_pkg::t_sample cosine);
        longint       x, y, m, xs, ys, mid, gain;
        scad_pkg::t_z z;
        mid = cal_sine_offset;
        gain = cal_sine_gain;
        y = (longint'(sine) - mid) * gain;
        mid = cal_cos_offset;
        gain = cal_cos_gain;
        x = (longint'(cosine) - mid) * gain;
        m = (x < 0) ? -x : x;
        if (((y < 0) ? -y : y) > m)
            m = (y < 0) ? -y : y;
        if (m == 0)
            return '0;
        while (m < NORM_FLOOR) begin
            m = m * 2;
            x = x * 2;
            y = y * 2;
        end
        z = '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = scad_pkg::HALF_TURN_Z;
        end
        for (int i = 0; i < scad_pkg::CORDIC_ITERATIONS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TURNS[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TURNS[i];
            end
        end
        // round half up, wraps to zero at a full turn
        z = z + (scad_pkg::t_z'(1) << (scad_pkg::Z_W - 1 - scad_pkg::ANGLE_FRAC_BITS));
        return scad_pkg::t_angle'(z >> (scad_pkg::Z_W - scad_pkg::ANGLE_FRAC_BITS));
    endfunction

    function automatic scad_pkg::t_phi stroke_of(input scad_pkg::t_angle raw);
        longint full, up, dn, t1, t2, dir, span, d;
        full = longint'(1) << scad_pkg::ANGLE_FRAC_BITS;
        up = cal_up_angle;
        dn = cal_down_angle;
        t1 = (up > dn) ? up - dn : up + full - dn;
        t2 = (dn > up) ? dn - up : dn + full - up;
        // shorter arc decides the direction, a tie goes negative
        if (t1 < t2) begin
            dir = 1;
            span = t1;
        end else begin
            dir = -1;
            span = t2;
        end
        d = (longint'(raw) - dn) & (full - 1);
        if (d > full / 2)
            d = d - full;
        return scad_pkg::t_phi'((2 * dir * d - span + 1) >>> 1);
    endfunction

    function automatic t_angle_word decode_angles(input scad_pkg::t_sample sine,
                                                  input scad_pkg::t_sample cosine);
        t_angle_word w;
        w.raw = atan2_turn(sine, cosine);
        w.phi = stroke_of(w.raw);
        return w;
    endfunction

    function automatic void load_reg(input scad_pkg::t_cfg_idx idx, input logic [31:0] data);
        case (idx)
            scad_pkg::REG_SINE_OFFSET:   cal_sine_offset = scad_pkg::t_sample'(data);
            scad_pkg::REG_SINE_SCALE:    cal_sine_gain = data;
            scad_pkg::REG_COSINE_OFFSET: cal_cos_offset = scad_pkg::t_sample'(data);
            scad_pkg::REG_COSINE_SCALE:  cal_cos_gain = data;
            scad_pkg::REG_UPSTROKE:      cal_up_angle = scad_pkg::t_angle'(data);
            scad_pkg::REG_DOWNSTROKE:    cal_down_angle = scad_pkg::t_angle'(data);
            default: ;
        endcase
    endfunction

    // random idle gap, with now and then a run of back-to-back words
    function automatic int draw_idle(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            run_left = $urandom_range(16, 64);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [31:0] pick_offset();
        case ($urandom_range(0, 4))
            0:       return 32'd0;
            1:       return 32'd32767;
            2:       return 32'd16384;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFFFFFF;
            2:       return 32'h40000000;
            3:       return $urandom;
            4:       return $urandom_range(0, 255);
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [31:0] pick_angle();
        case ($urandom_range(0, 4))
            0:       return 32'd0;
            1:       return 32'h0000FFFF;
            2:       return 32'h00008000;
            default: return $urandom;
        endcase
    endfunction

    // samples at or near the midpoint make tiny vectors and deep normalize shifts
    function automatic scad_pkg::t_sample pick_sample(input scad_pkg::t_sample mid);
        case ($urandom_range(0, 7))
            0:       return mid;
            1:       return mid + scad_pkg::t_sample'($urandom_range(0, 8))
                            - scad_pkg::t_sample'(4);
            2:       return '0;
            3:       return '1;
            default: return scad_pkg::t_sample'($urandom);
        endcase
    endfunction

    task automatic lower_valid();
        if (word_offered) begin
            i_in_valid <= 1'b0;
            word_offered = 1'b0;
        end
    endtask

    task automatic send_word(input scad_pkg::t_sample sine, input scad_pkg::t_sample cosine,
                             input t_angle_word want);
        int gap;
        gap = draw_idle(send_run);
        if (gap > 0) begin
            lower_valid();
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sine_sample <= sine;
        i_cosine_sample <= cosine;
        word_offered = 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        angles_in_flight.push_back(want);
    endtask

    task automatic drain_pipeline();
        lower_valid();
        while (angles_in_flight.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input scad_pkg::t_cfg_idx idx, input logic [31:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        load_reg(idx, data);
    endtask

    task automatic shuffle_calibration();
        write_reg(scad_pkg::REG_SINE_OFFSET, pick_offset());
        write_reg(scad_pkg::REG_SINE_SCALE, pick_gain());
        write_reg(scad_pkg::REG_COSINE_OFFSET, pick_offset());
        write_reg(scad_pkg::REG_COSINE_SCALE, pick_gain());
        write_reg(scad_pkg::REG_DOWNSTROKE, pick_angle());
        // equal limit angles now and then, junk in the upper bits
        if ($urandom_range(0, 3) == 0)
            write_reg(scad_pkg::REG_UPSTROKE, ($urandom & 32'hFFFF0000) | cal_down_angle);
        else
            write_reg(scad_pkg::REG_UPSTROKE, pick_angle());
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
    endtask

    // stimulus
    initial begin
        scad_pkg::t_sample sine, cosine;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < PROBE_ROWS; i++) begin
            if (PROBES[i].wr) begin
                drain_pipeline();
                write_reg(PROBES[i].idx, PROBES[i].data);
            end else if (PROBES[i].typed) begin
                send_word(PROBES[i].sine, PROBES[i].cosine, PROBES[i].word);
            end else begin
                send_word(PROBES[i].sine, PROBES[i].cosine,
                          decode_angles(PROBES[i].sine, PROBES[i].cosine));
            end
        end
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_pipeline();
            shuffle_calibration();
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                sine = pick_sample(cal_sine_offset);
                cosine = pick_sample(cal_cos_offset);
                send_word(sine, cosine, decode_angles(sine, cosine));
            end
        end
        drain_pipeline();
        repeat (END_SETTLE) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // output side: random stalls, every word checked against the oldest pending one
    initial begin
        t_angle_word want;
        int          stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = draw_idle(take_run);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            if (angles_in_flight.size() == 0) begin
                $error("output word with nothing pending: raw_angle %0d stroke_phi %0d",
                       o_raw_angle, o_stroke_phi);
                mismatch_count++;
            end else begin
                want = angles_in_flight.pop_front();
                if (o_raw_angle !== want.raw) begin
                    $error("raw_angle: expected %0d, got %0d", want.raw, o_raw_angle);
                    mismatch_count++;
                end
                if (o_stroke_phi !== want.phi) begin
                    $error("stroke_phi: expected %0d, got %0d", want.phi, o_stroke_phi);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles where neither side moves a word
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_ready === 1'b1) ||
                (o_out_valid === 1'b1 && i_out_ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule
